// ===== src/grff_pkg.sv =====
// Package: shared types, constants and state codes for the grid region flood fill block.
package grff_pkg;

    localparam int DEF_MAX_ROWS   = 32;
    localparam int DEF_MAX_COLS   = 32;
    localparam int DEF_VALUE_BITS = 8;

    localparam int CFG_IDX_BITS = 1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GRID_ROWS = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GRID_COLS = 1'b1;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic STATUS_DONE  = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    typedef struct packed {
        logic       cmd;
        logic [4:0] row;
        logic [4:0] col;
        logic [7:0] cell_value;
    } grff_in_t;

    typedef struct packed {
        logic        status;
        logic [10:0] region_size;
        logic [7:0]  start_value;
        logic [17:0] score;
    } grff_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_START_RD,
        ST_START_WAIT,
        ST_POP,
        ST_POP_WAIT,
        ST_NB_ISSUE,
        ST_NB_CHECK,
        ST_SCORE,
        ST_OUT
    } grff_state_t;

endpackage

// ===== src/grid_region_size_flood_fill_top.sv =====
// Top level: grid store, visited map, visit queue and the breadth-first search sequencer.
//
// An in-range write request is stored in the grid when it is accepted, and the
// next request can follow on the next cycle. A query request first clears every
// cell of the visited map, one cell per cycle. It then runs the breadth-first
// search: each queued cell is popped through ST_POP and ST_POP_WAIT, and each of
// its four neighbors is read in ST_NB_ISSUE and checked in ST_NB_CHECK when it
// lies inside the grid, and skipped in ST_NB_ISSUE alone when it does not. The
// grid and visited memories each have a single registered read port. An
// out-of-range query answers on the cycle after it is accepted. One request is
// worked on at a time; the result waits in an output register, and no new
// request is taken until that result is accepted.
module grid_region_size_flood_fill_top
    import grff_pkg::*;
#(
    parameter int MAX_ROWS   = DEF_MAX_ROWS,
    parameter int MAX_COLS   = DEF_MAX_COLS,
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  grff_in_t                in_data,
    output logic                    out_valid,
    input  logic                    out_ready,
    output grff_out_t               out_data,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [5:0]              cfg_data
);

    localparam int CELLS  = MAX_ROWS * MAX_COLS;
    localparam int RB     = $clog2(MAX_ROWS);
    localparam int CB     = $clog2(MAX_COLS);
    localparam int QB     = RB + CB;
    localparam int AB     = $clog2(CELLS);
    localparam int NB     = AB + 1;
    localparam int DIMB   = $clog2(MAX_ROWS > MAX_COLS ? MAX_ROWS + 1 : MAX_COLS + 1);

    // Configuration registers.
    logic [5:0] rows_reg, cols_reg;
    logic [DIMB:0] rows_use, cols_use;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= 6'd32;
            cols_reg <= 6'd32;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_GRID_ROWS: rows_reg <= cfg_data;
                CFG_GRID_COLS: cols_reg <= cfg_data;
                default: ;
            endcase
        end
    end
    assign cfg_ready = 1'b1;

    // Clamp the registers to the grid size.
    always_comb
    begin
        rows_use = (DIMB+1)'(rows_reg);
        cols_use = (DIMB+1)'(cols_reg);
        if (32'(rows_reg) > MAX_ROWS) rows_use = (DIMB+1)'(MAX_ROWS);
        if (32'(cols_reg) > MAX_COLS) cols_use = (DIMB+1)'(MAX_COLS);
    end

    // Memories. The queue holds row and column of each cell side by side.
    logic                  g_we, s_we, q_we;
    logic [AB-1:0]         g_wa, g_ra, s_wa, s_ra, q_wa, q_ra;
    logic [VALUE_BITS-1:0] g_wd, g_rd;
    logic                  s_wd, s_rd;
    logic [QB-1:0]         q_wd, q_rd;

    grff_ram #(.WIDTH(VALUE_BITS), .DEPTH(CELLS)) u_grid (
        .clk(clk), .we(g_we), .waddr(g_wa), .wdata(g_wd), .raddr(g_ra), .rdata(g_rd));
    grff_ram #(.WIDTH(1), .DEPTH(CELLS)) u_seen (
        .clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd));
    grff_ram #(.WIDTH(QB), .DEPTH(CELLS)) u_queue (
        .clk(clk), .we(q_we), .waddr(q_wa), .wdata(q_wd), .raddr(q_ra), .rdata(q_rd));

    // Sequencer registers.
    grff_state_t state_reg, state_next;
    logic [NB-1:0] head_reg, head_next, tail_reg, tail_next;
    logic [NB-1:0] clr_reg, clr_next;
    logic [RB-1:0] cr_reg, cr_next;
    logic [CB-1:0] cc_reg, cc_next;
    logic [1:0]    dir_reg, dir_next;
    logic [AB-1:0] nidx_reg, nidx_next;
    logic [QB-1:0] nrc_reg, nrc_next;
    logic [RB-1:0] sr_reg, sr_next;
    logic [CB-1:0] sc_reg, sc_next;
    logic [VALUE_BITS-1:0] tgt_reg, tgt_next;
    logic          out_valid_reg, out_valid_next;
    grff_out_t     out_reg, out_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        clr_reg  <= clr_next;
        cr_reg   <= cr_next;
        cc_reg   <= cc_next;
        dir_reg  <= dir_next;
        nidx_reg <= nidx_next;
        nrc_reg  <= nrc_next;
        sr_reg   <= sr_next;
        sc_reg   <= sc_next;
        tgt_reg  <= tgt_next;
        out_reg  <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign in_ready  = (state_reg == ST_IDLE) && !out_valid_reg;

    // Neighbor computation for the current direction.
    logic          nb_ok;
    logic [RB-1:0] nr;
    logic [CB-1:0] nc;
    logic          in_inside;
    logic [17:0]   prod;

    always_comb
    begin
        nb_ok = 1'b0;
        nr    = cr_reg;
        nc    = cc_reg;
        case (dir_reg)
            2'd0:
            begin
                nc    = cc_reg - 1'b1;
                nb_ok = (cc_reg != '0);
            end
            2'd1:
            begin
                nc    = cc_reg + 1'b1;
                nb_ok = ((DIMB+1)'(cc_reg) + 1'b1) < cols_use;
            end
            2'd2:
            begin
                nr    = cr_reg + 1'b1;
                nb_ok = ((DIMB+1)'(cr_reg) + 1'b1) < rows_use;
            end
            default:
            begin
                nr    = cr_reg - 1'b1;
                nb_ok = (cr_reg != '0);
            end
        endcase
    end

    assign in_inside = ((DIMB+1)'(in_data.row) < rows_use)
                    && ((DIMB+1)'(in_data.col) < cols_use)
                    && (32'(in_data.row) < MAX_ROWS) && (32'(in_data.col) < MAX_COLS);
    assign prod = 18'(tgt_reg) * 18'(tail_reg);

    // Next state and memory controls.
    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        clr_next       = clr_reg;
        cr_next        = cr_reg;
        cc_next        = cc_reg;
        dir_next       = dir_reg;
        nidx_next      = nidx_reg;
        nrc_next       = nrc_reg;
        sr_next        = sr_reg;
        sc_next        = sc_reg;
        tgt_next       = tgt_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        g_we = 1'b0; g_wa = '0; g_wd = '0; g_ra = '0;
        s_we = 1'b0; s_wa = '0; s_wd = 1'b0; s_ra = '0;
        q_we = 1'b0; q_wa = '0; q_wd = '0; q_ra = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    sr_next = RB'(in_data.row);
                    sc_next = CB'(in_data.col);
                    if (in_data.cmd == CMD_WRITE)
                    begin
                        g_we = in_inside;
                        g_wa = AB'(RB'(in_data.row) * MAX_COLS + CB'(in_data.col));
                        g_wd = VALUE_BITS'(in_data.cell_value);
                    end
                    else if (!in_inside)
                    begin
                        out_valid_next = 1'b1;
                        out_next       = '{STATUS_RANGE, 11'd0, 8'd0, 18'd0};
                    end
                    else
                    begin
                        clr_next   = '0;
                        state_next = ST_CLEAR;
                    end
                end
            end
            // Clear the visited map, one cell per cycle.
            ST_CLEAR:
            begin
                s_we     = 1'b1;
                s_wa     = clr_reg[AB-1:0];
                s_wd     = 1'b0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == NB'(CELLS - 1))
                begin
                    state_next = ST_START_RD;
                end
            end
            ST_START_RD:
            begin
                g_ra       = AB'(sr_reg * MAX_COLS + sc_reg);
                state_next = ST_START_WAIT;
            end
            // Seed the search with the start cell.
            ST_START_WAIT:
            begin
                tgt_next   = g_rd;
                s_we       = 1'b1;
                s_wa       = AB'(sr_reg * MAX_COLS + sc_reg);
                s_wd       = 1'b1;
                q_we       = 1'b1;
                q_wa       = '0;
                q_wd       = {sr_reg, sc_reg};
                head_next  = '0;
                tail_next  = NB'(1);
                state_next = ST_POP;
            end
            ST_POP:
            begin
                if (head_reg == tail_reg)
                begin
                    state_next = ST_SCORE;
                end
                else
                begin
                    q_ra       = head_reg[AB-1:0];
                    head_next  = head_reg + 1'b1;
                    state_next = ST_POP_WAIT;
                end
            end
            ST_POP_WAIT:
            begin
                cr_next    = q_rd[QB-1:CB];
                cc_next    = q_rd[CB-1:0];
                dir_next   = 2'd0;
                state_next = ST_NB_ISSUE;
            end
            // Read grid and visited map at the neighbor.
            ST_NB_ISSUE:
            begin
                if (nb_ok)
                begin
                    nidx_next  = AB'(nr * MAX_COLS + nc);
                    nrc_next   = {nr, nc};
                    g_ra       = AB'(nr * MAX_COLS + nc);
                    s_ra       = AB'(nr * MAX_COLS + nc);
                    state_next = ST_NB_CHECK;
                end
                else if (dir_reg == 2'd3)
                begin
                    state_next = ST_POP;
                end
                else
                begin
                    dir_next = dir_reg + 1'b1;
                end
            end
            // Mark and enqueue an unseen equal neighbor.
            ST_NB_CHECK:
            begin
                if (!s_rd && (g_rd == tgt_reg))
                begin
                    s_we      = 1'b1;
                    s_wa      = nidx_reg;
                    s_wd      = 1'b1;
                    q_we      = 1'b1;
                    q_wa      = tail_reg[AB-1:0];
                    q_wd      = nrc_reg;
                    tail_next = tail_reg + 1'b1;
                end
                dir_next   = dir_reg + 1'b1;
                state_next = (dir_reg == 2'd3) ? ST_POP : ST_NB_ISSUE;
            end
            ST_SCORE:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                out_valid_next = 1'b1;
                out_next       = '{STATUS_DONE, 11'(tail_reg), 8'(tgt_reg), prod};
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/grff_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
module grff_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/grff_checker.sv =====
// Port-level checker for the grid region flood fill block, bound to the top level.
module grff_checker
    import grff_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input grff_in_t  in_data,
    input logic      out_valid,
    input logic      out_ready,
    input grff_out_t out_data
);

    // A result holds until taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result dropped or changed while stalled");

    // An out-of-range status carries a zero region size and a zero score.
    a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == STATUS_RANGE |->
        out_data.region_size == 11'd0 && out_data.score == 18'd0)
        else $error("out-of-range result has nonzero fields");

    // A completed query has at least the start cell.
    a_size_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == STATUS_DONE |-> out_data.region_size != 11'd0)
        else $error("empty region reported");

    // No new request while a result waits.
    a_no_accept_pending: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("request accepted while result pending");

    // An accepted query keeps the input closed on the next cycle.
    a_query_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.cmd == CMD_QUERY |=> !in_ready)
        else $error("request accepted right after a query");

endmodule

bind grid_region_size_flood_fill_top grff_checker u_grff_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data));
